// ===== design/rsenc_pkg.sv =====
// ----------------------------------------------------------------------------
// rsenc_pkg
// Shared types, constants and GF(256) helpers for the Reed-Solomon encoder.
// ----------------------------------------------------------------------------
package rsenc_pkg;

  localparam int MAX_ECC_WORDS_DEFAULT = 30;
  localparam int ECC_WORDS_LIMIT = 64;
  localparam int ECC_WORDS_MIN = 2;
  localparam logic [4:0] ECC_WORDS_RESET = 5'd10;
  localparam logic [8:0] FIELD_POLY = 9'h11D;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] parity_byte;
    logic       last_parity;
  } out_item_t;

  typedef logic [ECC_WORDS_LIMIT:0][7:0] tap_row_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] x;
    logic [7:0] acc;
    x = {1'b0, a};
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc = acc ^ x[7:0];
      end
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ FIELD_POLY;
      end
    end
    return acc;
  endfunction

  // taps[k] is the generator coefficient of x^(n-k); zero above n
  function automatic tap_row_t gen_taps(input int n);
    logic [7:0] low [0:ECC_WORDS_LIMIT];
    logic [7:0] root;
    tap_row_t   taps;
    for (int k = 0; k <= ECC_WORDS_LIMIT; k++) begin
      low[k] = 8'h00;
    end
    low[0] = 8'h01;
    root = 8'h01;
    for (int i = 0; i < n; i++) begin
      for (int k = i + 1; k > 0; k--) begin
        low[k] = low[k-1] ^ gf_mul(low[k], root);
      end
      low[0] = gf_mul(low[0], root);
      root = gf_mul(root, 8'h02);
    end
    for (int k = 0; k <= ECC_WORDS_LIMIT; k++) begin
      taps[k] = (k <= n) ? low[n-k] : 8'h00;
    end
    return taps;
  endfunction

  function automatic int clamp_words(input logic [4:0] v, input int max_words);
    int n;
    n = int'(v);
    if (n < ECC_WORDS_MIN) begin
      n = ECC_WORDS_MIN;
    end
    if (n > max_words) begin
      n = max_words;
    end
    return n;
  endfunction

endpackage

// ===== design/rsenc_front.sv =====
// ----------------------------------------------------------------------------
// rsenc_front
// Accepts data bytes, runs the parallel LFSR division step and hands the
// finished remainder of each block to the parity queue.
// ----------------------------------------------------------------------------
module rsenc_front #(
  parameter int MAX_ECC_WORDS = rsenc_pkg::MAX_ECC_WORDS_DEFAULT,
  parameter int CW = $clog2(MAX_ECC_WORDS + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  rsenc_pkg::in_item_t                 item,
  output logic                                full,
  input  logic                                cfg_we,
  input  logic [4:0]                          cfg_data,
  output logic [CW-1:0]                       n_words,
  output logic                                q_push,
  output logic [MAX_ECC_WORDS-1:0][7:0]       q_wdata,
  input  logic                                q_full
);
  import rsenc_pkg::*;

  typedef logic [MAX_ECC_WORDS:0][7:0] tap_vec_t;
  typedef logic [MAX_ECC_WORDS:0][MAX_ECC_WORDS:0][7:0] tap_tab_t;

  function automatic tap_tab_t build_table();
    tap_tab_t tab;
    tap_row_t row;
    for (int n = 0; n <= MAX_ECC_WORDS; n++) begin
      row = gen_taps((n < ECC_WORDS_MIN) ? ECC_WORDS_MIN : n);
      for (int j = 0; j <= MAX_ECC_WORDS; j++) begin
        tab[n][j] = row[j];
      end
    end
    return tab;
  endfunction

  localparam tap_tab_t TAP_TABLE = build_table();

  logic [4:0]                    ecc_words;
  tap_vec_t                      taps;
  logic [MAX_ECC_WORDS-1:0][7:0] rem;
  logic [MAX_ECC_WORDS-1:0][7:0] rem_shift;
  logic [MAX_ECC_WORDS-1:0][7:0] rem_next;
  logic [7:0]                    fb;
  logic [4:0]                    load_words;
  logic [CW-1:0]                 load_n;
  logic                          accept;

  assign full = q_full;
  assign accept = push && !q_full;
  assign n_words = CW'(clamp_words(ecc_words, MAX_ECC_WORDS));
  assign load_words = rst ? ECC_WORDS_RESET : cfg_data;
  assign load_n = CW'(clamp_words(load_words, MAX_ECC_WORDS));
  assign fb = item.data_byte ^ rem[0];
  assign rem_shift = {8'h00, rem[MAX_ECC_WORDS-1:1]};

  always_comb begin
    for (int i = 0; i < MAX_ECC_WORDS; i++) begin
      rem_next[i] = rem_shift[i] ^ gf_mul(fb, taps[i+1]);
    end
  end

  assign q_push = accept && item.last_data;
  assign q_wdata = rem_next;

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      ecc_words <= load_words;
      taps <= TAP_TABLE[load_n];
      rem <= '0;
    end else if (accept) begin
      rem <= item.last_data ? '0 : rem_next;
    end
  end

endmodule

// ===== design/rsenc_queue.sv =====
// ----------------------------------------------------------------------------
// rsenc_queue
// Two-entry queue of finished remainders between the LFSR and the parity
// burst, so each side can stall on its own.
// ----------------------------------------------------------------------------
module rsenc_queue #(
  parameter int MAX_ECC_WORDS = rsenc_pkg::MAX_ECC_WORDS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic [MAX_ECC_WORDS-1:0][7:0] wdata,
  output logic                          full,
  output logic                          valid,
  output logic [MAX_ECC_WORDS-1:0][7:0] rdata,
  input  logic                          pop
);
  logic [MAX_ECC_WORDS-1:0][7:0] mem [2];
  logic                          wr_ptr;
  logic                          rd_ptr;
  logic [1:0]                    count;
  logic                          do_push;
  logic                          do_pop;

  assign full = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign rdata = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== design/rsenc_back.sv =====
// ----------------------------------------------------------------------------
// rsenc_back
// Parity burst: loads one remainder from the queue and shifts it out one
// byte per transaction, highest order first, marking the final byte.
// ----------------------------------------------------------------------------
module rsenc_back #(
  parameter int MAX_ECC_WORDS = rsenc_pkg::MAX_ECC_WORDS_DEFAULT,
  parameter int CW = $clog2(MAX_ECC_WORDS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [CW-1:0]                 n_words,
  input  logic                          q_valid,
  input  logic [MAX_ECC_WORDS-1:0][7:0] q_rdata,
  output logic                          q_pop,
  output logic                          empty,
  input  logic                          pop,
  output rsenc_pkg::out_item_t          result
);
  import rsenc_pkg::*;

  logic [MAX_ECC_WORDS-1:0][7:0] burst;
  logic [CW-1:0]                 cnt;
  logic                          active;
  logic                          is_last;
  logic                          take;

  assign empty = !active;
  assign is_last = (cnt == n_words - CW'(1));
  assign take = active && pop;
  assign q_pop = q_valid && (!active || (take && is_last));
  assign result.parity_byte = burst[0];
  assign result.last_parity = is_last;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      burst <= q_rdata;
    end else if (take) begin
      burst <= {8'h00, burst[MAX_ECC_WORDS-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt <= '0;
    end else if (q_pop) begin
      active <= 1'b1;
      cnt <= '0;
    end else if (take) begin
      if (is_last) begin
        active <= 1'b0;
        cnt <= '0;
      end else begin
        cnt <= cnt + CW'(1);
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    active |-> (cnt < n_words))
    else $error("parity count beyond degree");

  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    (take && is_last) |=> (!active || cnt == '0))
    else $error("burst did not restart after final parity");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (take && !is_last) |=> (active && cnt == $past(cnt) + CW'(1)))
    else $error("parity count did not advance");

  a_idle_load: assert property (@(posedge clk) disable iff (rst)
    (!active && q_valid) |=> (active && cnt == '0))
    else $error("queued remainder not loaded");

endmodule

// ===== design/reed_solomon_ecc_encoder.sv =====
// ----------------------------------------------------------------------------
// reed_solomon_ecc_encoder
// Systematic Reed-Solomon encoder over GF(256), field polynomial 0x11D.
// ----------------------------------------------------------------------------
// Input channel: an item (data byte, last flag) is taken at a clock edge with
// push high and full low. One data byte is absorbed per cycle by a parallel
// LFSR step while full is low; non-final bytes produce no output.
// Output channel: while empty is low, the oldest parity byte is on result;
// it is taken on an edge with pop high. After the last data byte of a block,
// ecc_words parity bytes follow, highest order first, the final one marked.
// Output timing: the remainder is registered in the queue when the last data
// byte is taken, then loaded into the burst register, which puts the first
// parity byte on result. With pop high the burst gives one byte per cycle,
// with no gap if the next block is queued. Throughput: one data byte per
// cycle while full is low. Finished remainders wait in a two-entry queue;
// full goes high when two blocks wait behind a running parity burst, either
// because pop is held low or blocks are shorter than their parity bursts.
// Reset (rst, synchronous): ecc_words returns to 10, the LFSR clears and all
// queued parity is dropped. Writing cfg_data with cfg_we sets ecc_words
// (clamped to 2..MAX_ECC_WORDS) and starts a new block; write only when idle.
// ----------------------------------------------------------------------------
module reed_solomon_ecc_encoder #(
  parameter int MAX_ECC_WORDS = rsenc_pkg::MAX_ECC_WORDS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  rsenc_pkg::in_item_t  item,
  output logic                 empty,
  input  logic                 pop,
  output rsenc_pkg::out_item_t result,
  input  logic                 cfg_we,
  input  logic [4:0]           cfg_data
);
  import rsenc_pkg::*;

  localparam int CW = $clog2(MAX_ECC_WORDS + 1);

  logic [CW-1:0]                 n_words;
  logic                          q_push;
  logic [MAX_ECC_WORDS-1:0][7:0] q_wdata;
  logic                          q_full;
  logic                          q_valid;
  logic [MAX_ECC_WORDS-1:0][7:0] q_rdata;
  logic                          q_pop;

  rsenc_front #(
    .MAX_ECC_WORDS(MAX_ECC_WORDS),
    .CW(CW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .item(item),
    .full(full),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .n_words(n_words),
    .q_push(q_push),
    .q_wdata(q_wdata),
    .q_full(q_full)
  );

  rsenc_queue #(
    .MAX_ECC_WORDS(MAX_ECC_WORDS)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .wdata(q_wdata),
    .full(q_full),
    .valid(q_valid),
    .rdata(q_rdata),
    .pop(q_pop)
  );

  rsenc_back #(
    .MAX_ECC_WORDS(MAX_ECC_WORDS),
    .CW(CW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .n_words(n_words),
    .q_valid(q_valid),
    .q_rdata(q_rdata),
    .q_pop(q_pop),
    .empty(empty),
    .pop(pop),
    .result(result)
  );

endmodule
